@@ hdl/textbook_rsa_char_encrypt_assert.svh @@
// assertion macros for the byte encryptor
`ifndef TEXTBOOK_RSA_CHAR_ENCRYPT_ASSERT_SVH
`define TEXTBOOK_RSA_CHAR_ENCRYPT_ASSERT_SVH
`define RSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// shared types and constants of the byte encryptor
// ----------------------------------------------------------------------------
package rsa_pkg;
    localparam int WORD_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_PRIME_P = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_PRIME_Q = 1'b1;
    localparam logic [WORD_W-1:0] ONE = 32'd1;
    localparam logic [WORD_W-1:0] TWO = 32'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULN,      // phi = (p-1)*(q-1) via shift-add; n = p*q set on entry
        ST_ECHK,      // start gcd(phi, e)
        ST_GCD,       // gcd by repeated modulo
        ST_EINC,
        ST_PREP,      // base mod n
        ST_BIT,       // examine exponent bit
        ST_MULA,      // acc*b mod n
        ST_MULB,      // b*b mod n
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [63:0] a;
        logic [63:0] b;
    } mm_req_t;
endpackage

@@ hdl/rsa_modmul.sv @@
// ----------------------------------------------------------------------------
// rsa_modmul
// shared sequential unit: computes (a*b) mod m, or a mod m when b is 1,
// with shift-add multiply and reduction interleaved, one bit a cycle
// ----------------------------------------------------------------------------
module rsa_modmul
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsa_pkg::mm_req_t    req,
    input  logic [63:0]         m,
    output logic                done,
    output logic [63:0]         res
);
    // interleaved: r = (2r + a_bit*b) mod m, msb first, 64 steps
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] r_reg, r_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [65:0] t1, t2;
    logic [64:0] bm;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        bm = {1'b0, b_reg};
        t1 = {1'b0, r_reg, 1'b0};
        if (t1 >= {1'b0, m}) t1 = t1 - {2'b0, m};
        t2 = t1 + (a_reg[63] ? {1'b0, bm} : 66'd0);
        if (t2 >= {2'b0, m}) t2 = t2 - {2'b0, m};
        if (req.start)
        begin
            a_next = req.a;
            b_next = req.b;
            r_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next = t2[63:0];
            a_next = {a_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign res  = r_reg;
endmodule

@@ hdl/textbook_rsa_char_encrypt.sv @@
// ----------------------------------------------------------------------------
// textbook_rsa_char_encrypt
// byte-wise textbook rsa: key derived from two primes, cipher = m^e mod n
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// input     | start / busy         | plain_byte
// result    | done strobe          | cipher_word
// config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
// every product or reduction runs on the shared modular multiplier
// an item keeps busy high through the base reduction, one squaring per
// exponent bit and one multiply per set bit; the first item after a prime
// write first computes phi and then runs one gcd search per candidate exponent
// reset clears control state and restores the primes to 17 and 31
// results cannot be stalled; done is high for one cycle
module textbook_rsa_char_encrypt
#(
    parameter int PRIME_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       plain_byte,
    output logic                             done,
    output logic [31:0]                      cipher_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsa_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [PRIME_WIDTH-1:0]           cfg_data
);
    rsa_pkg::state_t state_reg, state_next;
    logic [PRIME_WIDTH-1:0] p_reg, q_reg;
    logic        derived_reg, derived_next;
    logic [31:0] n_reg, n_next, e_reg, e_next;
    logic [63:0] phi_reg, phi_next, e64_reg, e64_next;
    logic [63:0] x_reg, x_next, y_reg, y_next;    // gcd operands
    logic [63:0] acc_reg, acc_next, b_reg, b_next;
    logic [31:0] exp_reg, exp_next;
    logic [7:0]  m_reg;
    logic [31:0] out_reg, out_next;
    logic        done_next, done_reg;
    rsa_pkg::mm_req_t mm_req;
    logic [63:0] mm_mod;
    logic        mm_done;
    logic [63:0] mm_res;
    logic [63:0] pm1, qm1;

    rsa_modmul u_mm (.clk(clk), .rst_n(rst_n), .req(mm_req), .m(mm_mod),
        .done(mm_done), .res(mm_res));

    assign pm1 = (p_reg == '0) ? 64'd0 : 64'(p_reg) - 64'd1;
    assign qm1 = (q_reg == '0) ? 64'd0 : 64'(q_reg) - 64'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsa_pkg::ST_IDLE: if (start) state_next = derived_reg ?
                                  rsa_pkg::ST_PREP : rsa_pkg::ST_MULN;
            rsa_pkg::ST_MULN: if (mm_done) state_next = rsa_pkg::ST_ECHK;
            rsa_pkg::ST_ECHK: state_next = (e64_reg >= phi_reg) ?
                                  rsa_pkg::ST_PREP : rsa_pkg::ST_GCD;
            rsa_pkg::ST_GCD:
                if (y_reg == 64'd0)
                    state_next = (x_reg == 64'd1) ? rsa_pkg::ST_PREP : rsa_pkg::ST_EINC;
            rsa_pkg::ST_EINC: state_next = rsa_pkg::ST_ECHK;
            rsa_pkg::ST_PREP: if (mm_done) state_next = rsa_pkg::ST_BIT;
            rsa_pkg::ST_BIT:
                if (exp_reg == 32'd0) state_next = rsa_pkg::ST_DONE;
                else state_next = exp_reg[0] ? rsa_pkg::ST_MULA : rsa_pkg::ST_MULB;
            rsa_pkg::ST_MULA: if (mm_done) state_next = rsa_pkg::ST_MULB;
            rsa_pkg::ST_MULB: if (mm_done) state_next = rsa_pkg::ST_BIT;
            rsa_pkg::ST_DONE: state_next = rsa_pkg::ST_IDLE;
            default: state_next = rsa_pkg::ST_IDLE;
        endcase
    end

    // gcd uses the shared unit too: x mod y as (x*1) mod y
    always_comb
    begin
        derived_next = derived_reg;
        n_next = n_reg; e_next = e_reg;
        phi_next = phi_reg; e64_next = e64_reg;
        x_next = x_reg; y_next = y_reg;
        acc_next = acc_reg; b_next = b_reg;
        exp_next = exp_reg;
        out_next = out_reg;
        done_next = 1'b0;
        mm_req = '0;
        mm_mod = {32'd0, n_reg};
        unique case (state_reg)
            rsa_pkg::ST_IDLE:
                if (start && !derived_reg)
                begin
                    // (p-1)*(q-1) fits below 2^64-1: reuse unit with that huge modulus
                    mm_req.start = 1'b1;
                    mm_req.a = pm1;
                    mm_req.b = qm1;
                    n_next = 32'(64'(p_reg) * 64'(q_reg));
                    e64_next = 64'd2;
                end
                else if (start)
                begin
                    mm_req.start = 1'b1;
                    mm_req.a = {56'd0, plain_byte};
                    mm_req.b = 64'd1;
                end
            rsa_pkg::ST_MULN:
            begin
                mm_mod = 64'hFFFF_FFFF_FFFF_FFFF;
                if (mm_done) phi_next = mm_res;
            end
            rsa_pkg::ST_ECHK:
            begin
                // gcd(phi, e): first step is phi mod e
                x_next = phi_reg;
                y_next = e64_reg;
                if (e64_reg >= phi_reg)
                begin
                    e_next = (phi_reg <= 64'd2) ? rsa_pkg::TWO : phi_reg[31:0];
                    derived_next = 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.a = {56'd0, m_reg};
                    mm_req.b = 64'd1;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.a = phi_reg;
                    mm_req.b = 64'd1;
                end
            end
            rsa_pkg::ST_GCD:
            begin
                mm_mod = y_reg;
                if (y_reg == 64'd0)
                begin
                    if (x_reg == 64'd1)
                    begin
                        e_next = e64_reg[31:0];
                        derived_next = 1'b1;
                        mm_req.start = 1'b1;
                        mm_req.a = {56'd0, m_reg};
                        mm_req.b = 64'd1;
                    end
                end
                else if (mm_done)
                begin
                    x_next = y_reg;
                    y_next = mm_res;
                    if (mm_res != 64'd0)
                    begin
                        mm_req.start = 1'b1;
                        mm_req.a = y_reg;
                        mm_req.b = 64'd1;
                    end
                end
            end
            rsa_pkg::ST_EINC: e64_next = e64_reg + 64'd1;
            rsa_pkg::ST_PREP:
                if (mm_done)
                begin
                    b_next = mm_res;
                    acc_next = (n_reg == rsa_pkg::ONE) ? 64'd0 : 64'd1;
                    exp_next = e_reg;
                end
            rsa_pkg::ST_BIT:
                if (exp_reg == 32'd0)
                begin
                    out_next = (n_reg == 32'd0) ? 32'd0 : acc_reg[31:0];
                    done_next = 1'b1;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.a = exp_reg[0] ? acc_reg : b_reg;
                    mm_req.b = b_reg;
                end
            rsa_pkg::ST_MULA:
                if (mm_done)
                begin
                    acc_next = mm_res;
                    mm_req.start = 1'b1;
                    mm_req.a = b_reg;
                    mm_req.b = b_reg;
                end
            rsa_pkg::ST_MULB:
                if (mm_done)
                begin
                    b_next = mm_res;
                    exp_next = {1'b0, exp_reg[31:1]};
                end
            rsa_pkg::ST_DONE: ;
            default: ;
        endcase
        // a config transfer invalidates the key
        if (cfg_valid && cfg_ready) derived_next = 1'b0;
    end

    // y==0 in gcd entry: x mod 0 handled by ST_GCD check (phi>e>=2 so y>0)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rsa_pkg::ST_IDLE;
            derived_reg <= 1'b0;
            done_reg    <= 1'b0;
            p_reg       <= PRIME_WIDTH'(17);
            q_reg       <= PRIME_WIDTH'(31);
        end
        else
        begin
            state_reg   <= state_next;
            derived_reg <= derived_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rsa_pkg::REG_PRIME_P) p_reg <= cfg_data;
                if (cfg_index == rsa_pkg::REG_PRIME_Q) q_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; e_reg <= e_next;
        phi_reg <= phi_next; e64_reg <= e64_next;
        x_reg <= x_next; y_reg <= y_next;
        acc_reg <= acc_next; b_reg <= b_next;
        exp_reg <= exp_next;
        out_reg <= out_next;
        if (start && state_reg == rsa_pkg::ST_IDLE) m_reg <= plain_byte;
    end

    assign busy        = (state_reg != rsa_pkg::ST_IDLE);
    // config held off while an item is being taken
    assign cfg_ready   = (state_reg == rsa_pkg::ST_IDLE) && !start;
    assign done        = done_reg;
    assign cipher_word = out_reg;
endmodule

@@ hdl/rsa_checker.sv @@
// ----------------------------------------------------------------------------
// rsa_checker
// port-level checks of the byte encryptor
// ----------------------------------------------------------------------------
`include "textbook_rsa_char_encrypt_assert.svh"
module rsa_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);
    `RSA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "no busy after start")
    `RSA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held")
    `RSA_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, !busy, "config while busy")
    `RSA_ASSERT_IMPL(a_done_busy, clk, rst_n, done, !cfg_ready || !busy, "done state")
endmodule

bind textbook_rsa_char_encrypt rsa_checker u_chk (.clk(clk), .rst_n(rst_n), .start(start),
    .busy(busy), .done(done), .cfg_ready(cfg_ready));
